// ===== hdl/qsm3_pkg.sv =====
`timescale 1ns / 1ps
package qsm3_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              occ;
        logic              gt;
    } t_cell_link;

endpackage

// ===== hdl/qsm3_cell.sv =====
`timescale 1ns / 1ps
module qsm3_cell
    import qsm3_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_key,
    input  t_cell_link        i_left,
    input  t_cell_link        i_right,
    output t_cell_link        o_link
);

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;
    logic              r_occ;
    logic              n_occ;
    logic              w_gt;

    // empty cells act as plus infinity
    assign w_gt = !r_occ || ($signed(r_val) > $signed(i_key));

    always_comb begin
        n_val = r_val;
        n_occ = r_occ;
        if (i_ctl.shift) begin
            n_val = i_right.val;
            n_occ = i_right.occ;
        end else if (i_ctl.insert && w_gt) begin
            n_val = i_left.gt ? i_left.val : i_key;
            n_occ = r_occ | i_left.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_link.val = r_val;
    assign o_link.occ = r_occ;
    assign o_link.gt  = w_gt;

endmodule

// ===== hdl/quicksort_median_of_three.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata                 | tlast       | tuser
// s_axis  | in  | [31:0] sample_value   | end_of_set  | -
// m_axis  | out | [31:0] sorted_value   | final_flag  | [0] overflow_flag
//
// load: one beat per cycle, each beat inserted into its sorted place in the cell row while it has room
// sort: no separate phase, every cell compares against the new beat in the same cycle
// emit: the stored beats (at most CAPACITY) after the last input beat, one per cycle while m_axis_tready is high
// input is not taken during emission; stalls on m_axis hold the row
// reset clears occupancy, count and overflow; stored values need no clearing
module quicksort_median_of_three
    import qsm3_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,  // [31:0] sample_value
    input  logic              i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [DATA_W-1:0] o_m_axis_tdata,  // [31:0] sorted_value
    output logic              o_m_axis_tlast,
    output logic              o_m_axis_tuser   // [0] overflow_flag
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_room;
    t_cell_ctl        w_ctl;
    t_cell_link       w_link  [CAPACITY];
    t_cell_link       w_left  [CAPACITY];
    t_cell_link       w_right [CAPACITY];

    assign w_room    = r_count < CNT_W'(CAPACITY);
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    assign w_ctl.insert = w_in_acc && w_room;
    assign w_ctl.shift  = w_out_acc;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_left[g] = '{val: '0, occ: 1'b1, gt: 1'b0};
            end else begin : g_body
                assign w_left[g] = w_link[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_right[g] = '{val: '0, occ: 1'b0, gt: 1'b1};
            end else begin : g_inner
                assign w_right[g] = w_link[g+1];
            end
            qsm3_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_key   (i_s_axis_tdata),
                .i_left  (w_left[g]),
                .i_right (w_right[g]),
                .o_link  (w_link[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = S_LOAD;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
                n_count = '0;
                n_ovf   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_m_axis_tvalid = (r_state == S_EMIT);
    assign o_m_axis_tdata  = w_link[0].val;
    assign o_m_axis_tlast  = (r_count == CNT_W'(1));
    assign o_m_axis_tuser  = r_ovf;

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_count != '0) && w_link[0].occ)
        else $error("emitting with an empty row");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_axis_tlast) |=> (r_state == S_LOAD) && !r_ovf && (r_count == '0))
        else $error("set not closed after final beat");

    a_row_empty_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_axis_tlast) |=> !w_link[0].occ)
        else $error("row not drained after final beat");

endmodule

// ===== tb/quicksort_median_of_three_tb.sv =====
`timescale 1ns / 1ps
module quicksort_median_of_three_tb;
    import qsm3_pkg::*;

    localparam int SET_CAP      = CAPACITY_DEF;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_ITEMS = 355;
    localparam int TIMEOUT_NS   = 400_000 * 2 * CLK_HALF;
    localparam int NUM_DIR      = 23;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last_flag;
        logic              ovf;
    } t_sorted_beat;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              typed;
        logic [DATA_W-1:0] typed_value;
        logic              typed_last;
        logic              typed_ovf;
    } t_dir_row;

    localparam t_dir_row DIR_TABLE [NUM_DIR] = '{
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0007, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0007, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0007, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0002, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'd60, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'd50, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'd40, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'd30, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'd20, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'd10, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h5555_5555, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h8000_0001, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h7FFF_FFFE, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;    // [31:0] sample_value
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // [31:0] sorted_value
    logic              m_tlast;
    logic              m_tuser;         // [0] overflow_flag

    logic signed [DATA_W-1:0] set_store [SET_CAP];
    int                       set_count = 0;
    bit                       set_overflow = 1'b0;
    t_sorted_beat             pending_sorted [$];
    int                       err_cnt = 0;
    int                       rx_burst_left = 0;

    quicksort_median_of_three DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("DONE: errors detected");
        $finish;
    end

    // collect the set, sort it on the marked beat and, when enqueue is set, queue the sorted beats
    task automatic absorb_sample(input logic [DATA_W-1:0] v, input logic l, input bit enqueue);
        logic signed [DATA_W-1:0] key;
        int j;
        if (set_count < SET_CAP) begin
            set_store[set_count] = v;
            set_count++;
        end else begin
            set_overflow = 1'b1;
        end
        if (l) begin
            for (int i = 1; i < set_count; i++) begin
                key = set_store[i];
                j = i - 1;
                while (j >= 0 && set_store[j] > key) begin
                    set_store[j + 1] = set_store[j];
                    j--;
                end
                set_store[j + 1] = key;
            end
            if (enqueue) begin
                for (int k = 0; k < set_count; k++)
                    pending_sorted.push_back('{set_store[k], k == set_count - 1, set_overflow});
            end
            set_count = 0;
            set_overflow = 1'b0;
        end
    endtask

    task automatic send_beat(input logic [DATA_W-1:0] v, input logic l, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        while (pending_sorted.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: rand_value = 32'h7FFF_FFFF;
                    1: rand_value = 32'h8000_0000;
                    2: rand_value = 32'h0000_0000;
                    default: rand_value = 32'hFFFF_FFFF;
                endcase
            end
            1: rand_value = $urandom_range(0, 15) - 8;
            default: rand_value = $urandom;
        endcase
    endfunction

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            int gap;
            if (rx_burst_left > 0) begin
                gap = 0;
                rx_burst_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                gap = 0;
                rx_burst_left = $urandom_range(8, 40);
            end else begin
                gap = $urandom_range(0, 11);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_sorted_beat exp_beat;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_sorted.size() == 0) begin
                $error("unexpected beat: sorted_value %0d", $signed(m_tdata));
                err_cnt++;
            end else begin
                exp_beat = pending_sorted.pop_front();
                if (m_tdata !== exp_beat.value) begin
                    $error("sorted_value expected %0d actual %0d",
                           $signed(exp_beat.value), $signed(m_tdata));
                    err_cnt++;
                end
                if (m_tlast !== exp_beat.last_flag) begin
                    $error("final_flag expected %0b actual %0b", exp_beat.last_flag, m_tlast);
                    err_cnt++;
                end
                if (m_tuser !== exp_beat.ovf) begin
                    $error("overflow_flag expected %0b actual %0b", exp_beat.ovf, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        int sent;
        int set_len;
        int gap;
        bit burst;
        int forced_len [3];
        logic [DATA_W-1:0] v;

        forced_len = '{SET_CAP, SET_CAP + 1, SET_CAP + 6};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_DIR; r++) begin
            send_beat(DIR_TABLE[r].value, DIR_TABLE[r].last, $urandom_range(0, 11));
            if (DIR_TABLE[r].typed)
                pending_sorted.push_back('{DIR_TABLE[r].typed_value, DIR_TABLE[r].typed_last,
                                           DIR_TABLE[r].typed_ovf});
            absorb_sample(DIR_TABLE[r].value, DIR_TABLE[r].last, !DIR_TABLE[r].typed);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        // full store, marked beat on a full store, and an overflowing set first
        sent = 0;
        for (int s = 0; sent < RANDOM_ITEMS; s++) begin
            if (s < 3)
                set_len = forced_len[s];
            else if ($urandom_range(0, 19) == 0)
                set_len = $urandom_range(SET_CAP - 4, SET_CAP + 4);
            else
                set_len = $urandom_range(1, 12);
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < set_len; k++) begin
                v = rand_value();
                gap = burst ? 0 : $urandom_range(0, 11);
                send_beat(v, k == set_len - 1, gap);
                absorb_sample(v, k == set_len - 1, 1'b1);
                sent++;
            end
            if ($urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
